@@ rtl/lrrf_pkg.sv @@
// Shared types, constants and tables of the lidar ring region filter.
`timescale 1ns / 1ps
package lrrf_pkg;

  localparam int COORD_W        = 24;
  localparam int SLOT_ID_W      = 6;
  localparam int TABLE_W        = 60;
  localparam int RING_SLOTS_DEF = 10;
  localparam int SQRT_STEPS     = 24;
  localparam int CORDIC_STEPS   = 24;
  localparam int CX_W           = 36;
  localparam int ANG_W          = 28;
  localparam int SID_W          = 10;
  localparam int SLOT_W         = 4;
  localparam int CFG_IDX_W      = 3;
  localparam int CFG_DATA_W     = 60;
  localparam int GAIN_Q16       = 8794089;
  localparam int OFFSET_Q16     = 3854564;

  typedef logic signed [COORD_W-1:0] coord_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_X_MAX      = 3'd0,
    REG_X_MIN      = 3'd1,
    REG_Y_MAX      = 3'd2,
    REG_Y_MIN      = 3'd3,
    REG_Z_CEILING  = 3'd4,
    REG_RING_TABLE = 3'd5
  } cfg_reg_t;

  typedef struct packed {
    logic   in_region;
    coord_t x;
    coord_t y;
    coord_t z;
  } point_side_t;

  function automatic logic signed [ANG_W-1:0] atan_step(input int i);
    logic signed [ANG_W-1:0] v;
    unique case (i)
      0:       v = 28'sd13176795;
      1:       v = 28'sd7778716;
      2:       v = 28'sd4110060;
      3:       v = 28'sd2086331;
      4:       v = 28'sd1047214;
      5:       v = 28'sd524117;
      6:       v = 28'sd262123;
      7:       v = 28'sd131069;
      default: v = ANG_W'(64'sd1 <<< (24 - i));
    endcase
    return v;
  endfunction

endpackage

@@ rtl/lrrf_point_if.sv @@
// Input channel carrying one lidar point per request.
`timescale 1ns / 1ps
interface lrrf_point_if;
  import lrrf_pkg::*;
  logic   valid;
  logic   ready;
  coord_t x_pos;
  coord_t y_pos;
  coord_t z_pos;
  logic   coords_finite;
  modport source (output valid, x_pos, y_pos, z_pos, coords_finite, input ready);
  modport sink   (input valid, x_pos, y_pos, z_pos, coords_finite, output ready);
endinterface

@@ rtl/lrrf_result_if.sv @@
// Output channel carrying one classified point per request.
`timescale 1ns / 1ps
interface lrrf_result_if;
  import lrrf_pkg::*;
  logic                     valid;
  logic                     ready;
  logic                     keep;
  logic [SLOT_W-1:0]        ring_slot;
  logic signed [SID_W-1:0]  scan_id;
  coord_t                   x_out;
  coord_t                   y_out;
  coord_t                   z_out;
  modport source (output valid, keep, ring_slot, scan_id, x_out, y_out, z_out,
                  input ready);
  modport sink   (input valid, keep, ring_slot, scan_id, x_out, y_out, z_out,
                  output ready);
endinterface

@@ rtl/lrrf_cfg_if.sv @@
// Configuration write channel: register index and write data.
`timescale 1ns / 1ps
interface lrrf_cfg_if;
  import lrrf_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

@@ rtl/lrrf_isqrt.sv @@
// Pipelined integer square root, one result bit per stage.
`timescale 1ns / 1ps
module lrrf_isqrt #(
  parameter int STEPS  = 24,
  parameter int SIDE_W = 8
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               en,
  input  logic               in_valid,
  input  logic [2*STEPS-1:0] in_n,
  input  logic [SIDE_W-1:0]  in_side,
  output logic               out_valid,
  output logic [STEPS-1:0]   out_root,
  output logic [SIDE_W-1:0]  out_side
);
  localparam int W = 2 * STEPS;

  logic [W-1:0]      op_q   [STEPS];
  logic [W-1:0]      res_q  [STEPS];
  logic              val_q  [STEPS];
  logic [SIDE_W-1:0] side_q [STEPS];

  genvar i;
  for (i = 0; i < STEPS; i++) begin : g_step
    localparam logic [W-1:0] ONE = W'(1) << (2 * (STEPS - 1 - i));
    logic [W-1:0]      op_in, res_in, trial, op_next, res_next;
    logic              val_in;
    logic [SIDE_W-1:0] side_in;

    if (i == 0) begin : g_first
      assign op_in   = in_n;
      assign res_in  = '0;
      assign val_in  = in_valid;
      assign side_in = in_side;
    end else begin : g_rest
      assign op_in   = op_q[i-1];
      assign res_in  = res_q[i-1];
      assign val_in  = val_q[i-1];
      assign side_in = side_q[i-1];
    end

    always_comb begin
      trial = res_in + ONE;
      if (op_in >= trial) begin
        op_next  = op_in - trial;
        res_next = (res_in >> 1) + ONE;
      end else begin
        op_next  = op_in;
        res_next = res_in >> 1;
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        val_q[i] <= 1'b0;
      end else if (en) begin
        val_q[i] <= val_in;
      end
      if (en) begin
        op_q[i]   <= op_next;
        res_q[i]  <= res_next;
        side_q[i] <= side_in;
      end
    end
  end

  assign out_valid = val_q[STEPS-1];
  assign out_root  = res_q[STEPS-1][STEPS-1:0];
  assign out_side  = side_q[STEPS-1] ^ SIDE_W'(op_q[STEPS-1] & '0);
endmodule

@@ rtl/lrrf_cordic.sv @@
// Pipelined CORDIC vectoring, one micro-rotation per stage.
`timescale 1ns / 1ps
module lrrf_cordic #(
  parameter int STEPS  = 24,
  parameter int ROOT_W = 24
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               en,
  input  logic                               in_valid,
  input  logic [ROOT_W-1:0]                  in_r,
  input  lrrf_pkg::point_side_t              in_side,
  output logic                               out_valid,
  output logic signed [lrrf_pkg::ANG_W-1:0]  out_ang,
  output lrrf_pkg::point_side_t              out_side
);
  import lrrf_pkg::*;

  logic signed [CX_W-1:0]  cx_q   [STEPS];
  logic signed [CX_W-1:0]  cy_q   [STEPS];
  logic signed [ANG_W-1:0] ang_q  [STEPS];
  logic                    val_q  [STEPS];
  point_side_t             side_q [STEPS];

  genvar i;
  for (i = 0; i < STEPS; i++) begin : g_step
    logic signed [CX_W-1:0]  cx_in, cy_in, dx, dy, cx_next, cy_next;
    logic signed [ANG_W-1:0] ang_in, ang_next;
    logic                    val_in;
    point_side_t             side_in;

    if (i == 0) begin : g_first
      assign cx_in   = $signed(CX_W'(in_r)) <<< 8;
      assign cy_in   = CX_W'(in_side.z) <<< 8;
      assign ang_in  = '0;
      assign val_in  = in_valid;
      assign side_in = in_side;
    end else begin : g_rest
      assign cx_in   = cx_q[i-1];
      assign cy_in   = cy_q[i-1];
      assign ang_in  = ang_q[i-1];
      assign val_in  = val_q[i-1];
      assign side_in = side_q[i-1];
    end

    always_comb begin
      dx = cy_in >>> i;
      dy = cx_in >>> i;
      if (!cy_in[CX_W-1]) begin
        cx_next  = cx_in + dx;
        cy_next  = cy_in - dy;
        ang_next = ang_in + atan_step(i);
      end else begin
        cx_next  = cx_in - dx;
        cy_next  = cy_in + dy;
        ang_next = ang_in - atan_step(i);
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        val_q[i] <= 1'b0;
      end else if (en) begin
        val_q[i] <= val_in;
      end
      if (en) begin
        cx_q[i]   <= cx_next;
        cy_q[i]   <= cy_next;
        ang_q[i]  <= ang_next;
        side_q[i] <= side_in;
      end
    end
  end

  assign out_valid = val_q[STEPS-1];
  assign out_ang   = ang_q[STEPS-1] + ANG_W'((cx_q[STEPS-1] ^ cy_q[STEPS-1]) & '0);
  assign out_side  = side_q[STEPS-1];
endmodule

@@ rtl/lrrf_ring_match.sv @@
// Scale angle to scan id and look it up in the wanted ring table.
`timescale 1ns / 1ps
module lrrf_ring_match #(
  parameter int RING_SLOTS = lrrf_pkg::RING_SLOTS_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                en,
  input  logic                                in_valid,
  input  logic signed [lrrf_pkg::ANG_W-1:0]   in_ang,
  input  lrrf_pkg::point_side_t               in_side,
  input  logic [lrrf_pkg::TABLE_W-1:0]        ring_table,
  output logic                                out_valid,
  output logic                                out_keep,
  output logic [lrrf_pkg::SLOT_W-1:0]         out_slot,
  output logic signed [lrrf_pkg::SID_W-1:0]   out_sid,
  output lrrf_pkg::point_side_t               out_side
);
  import lrrf_pkg::*;

  localparam int PROD_W = 53;
  localparam int Q_W    = PROD_W - 40;
  localparam logic signed [24:0]       GAIN     = 25'(GAIN_Q16);
  localparam logic signed [PROD_W-1:0] OFFSET_S = PROD_W'(OFFSET_Q16) <<< 24;

  logic                    v1, v2, v3;
  point_side_t             sd1, sd2, sd3;
  logic signed [PROD_W-1:0] prod, s_sum;
  logic [PROD_W-1:0]       mag;
  logic                    neg3;
  logic [Q_W-1:0]          q3;

  logic signed [Q_W-1:0]   sid_wide;
  logic                    found;
  logic [SLOT_W-1:0]       slot_sel;

  always_comb begin
    mag = s_sum[PROD_W-1] ? PROD_W'(-s_sum) : PROD_W'(s_sum);
  end

  always_comb begin
    sid_wide = neg3 ? -$signed(q3) : $signed(q3);
    if (!sd3.in_region) begin
      sid_wide = '0;
    end
    found    = 1'b0;
    slot_sel = '0;
    for (int k = 0; k < RING_SLOTS; k++) begin
      if (!found && sd3.in_region && sid_wide[Q_W-1:SLOT_ID_W] == '0 &&
          sid_wide[SLOT_ID_W-1:0] == ring_table[SLOT_ID_W*k +: SLOT_ID_W]) begin
        found    = 1'b1;
        slot_sel = SLOT_W'(k);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      v3        <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      v1        <= in_valid;
      v2        <= v1;
      v3        <= v2;
      out_valid <= v3;
    end
    if (en) begin
      prod     <= in_ang * GAIN;
      sd1      <= in_side;
      s_sum    <= prod + OFFSET_S;
      sd2      <= sd1;
      neg3     <= s_sum[PROD_W-1];
      q3       <= mag[PROD_W-1:40];
      sd3      <= sd2;
      out_keep <= found;
      out_slot <= slot_sel;
      out_sid  <= sid_wide[SID_W-1:0];
      out_side <= sd3;
    end
  end
endmodule

@@ rtl/lidar_ring_region_filter.sv @@
// Top level of the lidar ring region filter.
// Stages from request to result: region check, squares, sum, 24 square-root stages,
// 24 CORDIC stages, 4 scaling and lookup stages.
// Throughput: one point per cycle; a stall on the result side holds every stage.
// Reset: synchronous, clears all valid bits and loads the default region and ring table.
`timescale 1ns / 1ps
module lidar_ring_region_filter #(
  parameter int RING_SLOTS = lrrf_pkg::RING_SLOTS_DEF
) (
  input  logic          clk,
  input  logic          rst,
  lrrf_point_if.sink    point,
  lrrf_cfg_if.sink      cfg,
  lrrf_result_if.source result
);
  import lrrf_pkg::*;

  localparam int SQ_W   = 2 * SQRT_STEPS;
  localparam int SIDE_W = $bits(point_side_t);

  coord_t             x_max, x_min, y_max, y_min, z_ceiling;
  logic [TABLE_W-1:0] ring_table;

  logic en;
  assign en          = !result.valid || result.ready;
  assign point.ready = en;
  assign cfg.ready   = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      x_max      <= 24'sd30720;
      x_min      <= 24'sd0;
      y_max      <= 24'sd20480;
      y_min      <= -24'sd10240;
      z_ceiling  <= -24'sd1536;
      ring_table <= 60'd786624195013502681;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        REG_X_MAX:      x_max      <= cfg.data[COORD_W-1:0];
        REG_X_MIN:      x_min      <= cfg.data[COORD_W-1:0];
        REG_Y_MAX:      y_max      <= cfg.data[COORD_W-1:0];
        REG_Y_MIN:      y_min      <= cfg.data[COORD_W-1:0];
        REG_Z_CEILING:  z_ceiling  <= cfg.data[COORD_W-1:0];
        REG_RING_TABLE: ring_table <= cfg.data[TABLE_W-1:0];
        default: ;
      endcase
    end
  end

  logic        a_valid, b_valid, c_valid;
  point_side_t a_side, b_side, c_side;
  logic        in_region_next;
  logic [SQ_W-1:0] sq_x, sq_y, sq_sum;

  always_comb begin
    in_region_next = point.coords_finite &&
                     point.x_pos >= x_min && point.x_pos <= x_max &&
                     point.y_pos >= y_min && point.y_pos <= y_max &&
                     point.z_pos <= z_ceiling;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
      b_valid <= 1'b0;
      c_valid <= 1'b0;
    end else if (en) begin
      a_valid <= point.valid;
      b_valid <= a_valid;
      c_valid <= b_valid;
    end
    if (en) begin
      a_side <= '{in_region: in_region_next, x: point.x_pos, y: point.y_pos,
                  z: point.z_pos};
      sq_x   <= SQ_W'(SQ_W'(a_side.x) * SQ_W'(a_side.x));
      sq_y   <= SQ_W'(SQ_W'(a_side.y) * SQ_W'(a_side.y));
      b_side <= a_side;
      sq_sum <= sq_x + sq_y;
      c_side <= b_side;
    end
  end

  logic              r_valid;
  logic [SQRT_STEPS-1:0] r_root;
  logic [SIDE_W-1:0] r_side_bits;
  point_side_t       r_side;

  lrrf_isqrt #(
    .STEPS  (SQRT_STEPS),
    .SIDE_W (SIDE_W)
  ) u_isqrt (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (c_valid),
    .in_n      (sq_sum),
    .in_side   (c_side),
    .out_valid (r_valid),
    .out_root  (r_root),
    .out_side  (r_side_bits)
  );
  assign r_side = r_side_bits;

  logic                    g_valid;
  logic signed [ANG_W-1:0] g_ang;
  point_side_t             g_side;

  lrrf_cordic #(
    .STEPS  (CORDIC_STEPS),
    .ROOT_W (SQRT_STEPS)
  ) u_cordic (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (r_valid),
    .in_r      (r_root),
    .in_side   (r_side),
    .out_valid (g_valid),
    .out_ang   (g_ang),
    .out_side  (g_side)
  );

  point_side_t o_side;

  lrrf_ring_match #(
    .RING_SLOTS (RING_SLOTS)
  ) u_match (
    .clk        (clk),
    .rst        (rst),
    .en         (en),
    .in_valid   (g_valid),
    .in_ang     (g_ang),
    .in_side    (g_side),
    .ring_table (ring_table),
    .out_valid  (result.valid),
    .out_keep   (result.keep),
    .out_slot   (result.ring_slot),
    .out_sid    (result.scan_id),
    .out_side   (o_side)
  );

  assign result.x_out = o_side.x;
  assign result.y_out = o_side.y;
  assign result.z_out = o_side.z;
endmodule

@@ sim/lrrf_scoreboard.sv @@
// Checker for the lidar ring region filter: predicts each point's class and compares results.
`timescale 1ns / 1ps
module lrrf_scoreboard
  import lrrf_pkg::*;
(
  input  logic          clk,
  input  logic          rst,
  lrrf_point_if.sink    point,
  lrrf_cfg_if.sink      cfg,
  lrrf_result_if.sink   result,
  output int            fail_count,
  output int            pending
);

  typedef struct {
    logic                    keep;
    logic [SLOT_W-1:0]       ring_slot;
    logic signed [SID_W-1:0] scan_id;
    coord_t                  x;
    coord_t                  y;
    coord_t                  z;
  } class_t;

  class_t expected_q[$];
  coord_t lim_x_max, lim_x_min, lim_y_max, lim_y_min, lim_z_ceil;
  logic [TABLE_W-1:0] wanted_rings;

  localparam longint ATAN_TAB [CORDIC_STEPS] = '{
    13176795, 7778716, 4110060, 2086331, 1047214, 524117, 262123, 131069,
    65536, 32768, 16384, 8192, 4096, 2048, 1024, 512,
    256, 128, 64, 32, 16, 8, 4, 2};

  function automatic longint root_floor(longint unsigned n);
    longint unsigned rem, res, bitv;
    rem = n;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > rem) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (rem >= res + bitv) begin
        rem = rem - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return longint'(res);
  endfunction

  function automatic longint elev_angle(longint x, longint y, longint z);
    longint cx, cy, ang, dx, dy;
    cx = root_floor(longint'(x * x + y * y)) * 256;
    cy = z * 256;
    ang = 0;
    for (int i = 0; i < CORDIC_STEPS; i++) begin
      dx = cy >>> i;
      dy = cx >>> i;
      if (cy >= 0) begin
        cx += dx; cy -= dy; ang += ATAN_TAB[i];
      end else begin
        cx -= dx; cy += dy; ang -= ATAN_TAB[i];
      end
    end
    return ang;
  endfunction

  function automatic class_t classify(coord_t x, coord_t y, coord_t z, logic fin);
    class_t c;
    longint s, sid;
    c.keep = 0; c.ring_slot = 0; c.scan_id = 0; c.x = x; c.y = y; c.z = z;
    if (fin && x >= lim_x_min && x <= lim_x_max && y >= lim_y_min && y <= lim_y_max
        && z <= lim_z_ceil) begin
      s = elev_angle(x, y, z) * longint'(GAIN_Q16) + longint'(OFFSET_Q16) * 64'sd16777216;
      sid = (s >= 0) ? (s >>> 40) : -((-s) >>> 40);
      c.scan_id = sid[SID_W-1:0];
      for (int k = RING_SLOTS_DEF - 1; k >= 0; k--)
        if (sid == longint'(wanted_rings[6*k +: 6])) begin
          c.keep = 1;
          c.ring_slot = k[SLOT_W-1:0];
        end
    end
    return c;
  endfunction

  task automatic report(string what);
    $display("mismatch at %0t: %s", $time, what);
    fail_count++;
  endtask

  assign pending = expected_q.size();

  initial fail_count = 0;

  always @(posedge clk) begin
    class_t e;
    if (rst) begin
      lim_x_max <= 24'sd30720; lim_x_min <= 24'sd0; lim_y_max <= 24'sd20480;
      lim_y_min <= -24'sd10240; lim_z_ceil <= -24'sd1536;
      wanted_rings <= 60'd786624195013502681;
    end else begin
      if (cfg.valid && cfg.ready) begin
        case (cfg.index)
          REG_X_MAX:      lim_x_max <= cfg.data[COORD_W-1:0];
          REG_X_MIN:      lim_x_min <= cfg.data[COORD_W-1:0];
          REG_Y_MAX:      lim_y_max <= cfg.data[COORD_W-1:0];
          REG_Y_MIN:      lim_y_min <= cfg.data[COORD_W-1:0];
          REG_Z_CEILING:  lim_z_ceil <= cfg.data[COORD_W-1:0];
          REG_RING_TABLE: wanted_rings <= cfg.data;
          default: ;
        endcase
      end
      if (point.valid && point.ready)
        expected_q.insert(expected_q.size(),
                          classify(point.x_pos, point.y_pos, point.z_pos,
                                   point.coords_finite));
      if (result.valid && result.ready) begin
        if (expected_q.size() == 0) begin
          report("result with nothing expected");
        end else begin
          e = expected_q.pop_front();
          if (result.keep !== e.keep)
            report($sformatf("keep %b want %b", result.keep, e.keep));
          if (result.ring_slot !== e.ring_slot)
            report($sformatf("ring_slot %0d want %0d", result.ring_slot, e.ring_slot));
          if (result.scan_id !== e.scan_id)
            report($sformatf("scan_id %0d want %0d", result.scan_id, e.scan_id));
          if (result.x_out !== e.x || result.y_out !== e.y || result.z_out !== e.z)
            report($sformatf("coords %0d,%0d,%0d want %0d,%0d,%0d", result.x_out,
                   result.y_out, result.z_out, e.x, e.y, e.z));
        end
      end
    end
  end

endmodule

@@ sim/lidar_ring_region_filter_tb.sv @@
// Testbench top: drives points and register writes into the filter and gives the verdict.
`timescale 1ns / 1ps
module lidar_ring_region_filter_tb;
  import lrrf_pkg::*;

  logic clk = 0;
  logic rst = 1;
  int   fail_count, pending;
  bit   calm = 0;

  lrrf_point_if  point();
  lrrf_cfg_if    cfg();
  lrrf_result_if result();

  lidar_ring_region_filter dut (.clk(clk), .rst(rst), .point(point), .cfg(cfg),
                                .result(result));
  lrrf_scoreboard checker_i (.clk(clk), .rst(rst), .point(point), .cfg(cfg),
                             .result(result), .fail_count(fail_count), .pending(pending));

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  initial begin
    point.valid = 0; point.x_pos = 0; point.y_pos = 0; point.z_pos = 0;
    point.coords_finite = 0;
    cfg.valid = 0; cfg.index = REG_X_MAX; cfg.data = 0;
    result.ready = 0;
  end

  always @(posedge clk)
    result.ready <= rst ? 1'b0 : (calm || $urandom_range(99) >= 6);

  task automatic send_point(int x, int y, int z, bit fin);
    while (!calm && $urandom_range(99) < 6) begin
      point.valid <= 0;
      @(posedge clk);
    end
    point.valid <= 1;
    point.x_pos <= coord_t'(x); point.y_pos <= coord_t'(y); point.z_pos <= coord_t'(z);
    point.coords_finite <= fin;
    do @(posedge clk); while (!point.ready);
  endtask

  task automatic drain();
    point.valid <= 0;
    while (pending != 0) @(posedge clk);
    repeat (70) @(posedge clk);
  endtask

  task automatic write_reg(cfg_reg_t idx, logic [CFG_DATA_W-1:0] val);
    cfg.valid <= 1; cfg.index <= idx; cfg.data <= val;
    do @(posedge clk); while (!cfg.ready);
    cfg.valid <= 0;
    @(posedge clk);
  endtask

  task automatic set_region(int xmx, int xmn, int ymx, int ymn, int zc,
                            logic [TABLE_W-1:0] tab);
    write_reg(REG_X_MAX, 60'(xmx)); write_reg(REG_X_MIN, 60'(xmn));
    write_reg(REG_Y_MAX, 60'(ymx)); write_reg(REG_Y_MIN, 60'(ymn));
    write_reg(REG_Z_CEILING, 60'(zc)); write_reg(REG_RING_TABLE, tab);
  endtask

  function automatic logic [TABLE_W-1:0] rand_table();
    logic [TABLE_W-1:0] t;
    for (int k = 0; k < 10; k++) t[6*k +: 6] = 6'($urandom_range(63));
    return t;
  endfunction

  // random point biased toward the region and toward matching elevations
  task automatic random_points(int n, int spread);
    int x, y, z;
    for (int i = 0; i < n; i++) begin
      calm = (i >= n / 3 && i < n / 2);
      case ($urandom_range(9))
        0: begin x = int'($urandom); y = int'($urandom); z = int'($urandom); end
        1, 2: begin
          x = int'($urandom_range(2 * spread)) - spread;
          y = int'($urandom_range(2 * spread)) - spread;
          z = int'($urandom_range(2 * spread)) - spread;
        end
        default: begin
          x = int'($urandom_range(spread));
          y = int'($urandom_range(2 * spread)) - spread;
          z = -int'($urandom_range(spread / 2));
        end
      endcase
      send_point(x, y, z, $urandom_range(15) != 0);
    end
    calm = 0;
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst <= 0;
    @(posedge clk);
    send_point(1000, 0, -2000, 1'b1);
    send_point(10000, 100, -1600, 1'b1);
    send_point(0, 0, -1536, 1'b1);
    send_point(30720, 20480, -1536, 1'b1);
    send_point(30721, 0, -5000, 1'b1);
    send_point(5000, -10240, -3000, 1'b1);
    send_point(5000, -10241, -3000, 1'b1);
    send_point(5000, 0, -1535, 1'b1);
    send_point(5000, 0, -3000, 1'b0);
    send_point(20000, 1000, -2000, 1'b1);
    drain();
    set_region(8388607, -8388608, 8388607, -8388608, 8388607, 60'hFFFFFFFFFFFFFFF);
    send_point(8388607, 8388607, 8388607, 1'b1);
    send_point(-8388608, -8388608, -8388608, 1'b1);
    send_point(0, 0, 0, 1'b1);
    send_point(0, 0, 100, 1'b1);
    send_point(0, 0, -100, 1'b1);
    send_point(-8388608, 0, 8388607, 1'b1);
    send_point(1, 0, -8388608, 1'b1);
    send_point(8388607, -8388608, 0, 1'b1);
    random_points(150, 8388607);
    drain();
    set_region(8388607, -8388608, 8388607, -8388608, 8388607,
               {6'd40, 6'd40, 6'd30, 6'd30, 6'd20, 6'd20, 6'd10, 6'd59, 6'd0, 6'd63});
    random_points(250, 60000);
    drain();
    set_region(60000, -60000, 60000, -60000, 30000, rand_table());
    random_points(250, 70000);
    drain();
    set_region(-100, -8388608, 0, -8388608, -8388608, rand_table());
    random_points(20, 8388607);
    drain();
    write_reg(cfg_reg_t'(3'd7), 60'd0);
    write_reg(cfg_reg_t'(3'd6), 60'hFFFFFFFFFFFFFFF);
    set_region(30720, 0, 20480, -10240, -1536, 60'd786624195013502681);
    random_points(230, 30000);
    drain();
    if (fail_count == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end

  initial begin
    #3000000;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
